// ===== rtl/core/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared constants and types for the multitap feedback delay unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mfd_pkg;

    localparam int MFD_DELAY_DEPTH = 65536;
    localparam int MFD_SAMPLE_BITS = 24;

    localparam int DELAY_W     = 24;  // Q16.8 tap delay
    localparam int GAIN_W      = 16;  // Q2.14 signed gain
    localparam int SEND_W      = 7;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 3;
    localparam int MAC_A_W     = 17;  // shared multiplier, coefficient side

    localparam logic [31:0] PREFILTER_RESET = 32'h0000_4000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTRE_DELAY    = 3'd0,
        REG_LEFT_DELAY      = 3'd1,
        REG_RIGHT_DELAY     = 3'd2,
        REG_LOOP_GAIN       = 3'd3,
        REG_PREFILTER_GAINS = 3'd4,
        REG_TAP_LEVELS      = 3'd5,
        REG_MASTER_LEVEL    = 3'd6,
        REG_SEND_LEVEL      = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic en;        // update the accumulator
        logic clear;     // start from zero instead of the running sum
        logic shift_hi;  // product weighted by 2^24 (upper half of a split multiply)
    } mac_ctl_t;

    localparam mac_ctl_t MAC_HOLD   = '{en: 1'b0, clear: 1'b0, shift_hi: 1'b0};
    localparam mac_ctl_t MAC_LOAD   = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0};
    localparam mac_ctl_t MAC_ADD    = '{en: 1'b1, clear: 1'b0, shift_hi: 1'b0};
    localparam mac_ctl_t MAC_ADD_HI = '{en: 1'b1, clear: 1'b0, shift_hi: 1'b1};

endpackage

`default_nettype wire

// ===== rtl/core/mfd_tap_addr.sv =====
// ----------------------------------------------------------------------------
// mfd_tap_addr
// Clamps one Q16.8 tap delay and forms the two memory addresses it reads.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_tap_addr #(
    parameter int DELAY_DEPTH = mfd_pkg::MFD_DELAY_DEPTH,
    parameter int AW          = $clog2(DELAY_DEPTH)
) (
    input  wire logic [mfd_pkg::DELAY_W-1:0] dly,
    input  wire logic [AW-1:0]               wptr,
    output logic                             tap_on,
    output logic [7:0]                       frac,
    output logic [AW-1:0]                    new_addr,
    output logic [AW-1:0]                    old_addr
);
    import mfd_pkg::*;

    localparam logic [28:0] LO_C = 29'd256;
    localparam logic [28:0] HI_C = 29'((DELAY_DEPTH - 2) * 256);

    logic [28:0] dly_ext;
    logic [28:0] dly_clamped;
    logic [AW-1:0] whole;
    logic [AW:0]   diff;

    assign dly_ext = {5'b0, dly};
    assign tap_on  = |dly;

    always_comb
    begin
        priority if (dly_ext < LO_C)
        begin
            dly_clamped = LO_C;
        end
        else if (dly_ext > HI_C)
        begin
            dly_clamped = HI_C;
        end
        else
        begin
            dly_clamped = dly_ext;
        end
    end

    assign whole = dly_clamped[8 +: AW];
    assign frac  = dly_clamped[7:0];

    // A borrow means the tap lies behind the start of the ring.
    assign diff     = {1'b0, wptr} - {1'b0, whole};
    assign new_addr = diff[AW] ? diff[AW-1:0] + AW'(DELAY_DEPTH) : diff[AW-1:0];
    assign old_addr = (new_addr == '0) ? AW'(DELAY_DEPTH - 1) : new_addr - AW'(1);

endmodule

`default_nettype wire

// ===== rtl/core/mfd_delay_mem.sv =====
// ----------------------------------------------------------------------------
// mfd_delay_mem
// Delay memory with one read port, one write port and registered read.
// Entries that have not been written since reset read as zero; the ring is
// written strictly in order, so everything below the write pointer, or
// everything once it has wrapped, holds real data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_delay_mem #(
    parameter int DELAY_DEPTH = mfd_pkg::MFD_DELAY_DEPTH,
    parameter int SAMPLE_BITS = mfd_pkg::MFD_SAMPLE_BITS,
    parameter int AW          = $clog2(DELAY_DEPTH)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   rd_en,
    input  wire logic [AW-1:0]          rd_addr,
    input  wire logic                   wr_en,
    input  wire logic [AW-1:0]          wptr,
    input  wire logic [SAMPLE_BITS-1:0] wr_data,
    output logic [SAMPLE_BITS-1:0]      rd_data
);
    import mfd_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_q_reg;
    logic                   filled_reg;
    logic                   hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en && (wptr == AW'(DELAY_DEPTH - 1)))
            begin
                filled_reg <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= filled_reg || (rd_addr < wptr);
            end
        end
    end

    assign rd_data = hit_reg ? rd_q_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/core/mfd_mac.sv =====
// ----------------------------------------------------------------------------
// mfd_mac
// Shared signed multiply-accumulate through which every product of the sample goes.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_mac #(
    parameter int BW   = 30,
    parameter int ACCW = 58
) (
    input  wire logic                                clk,
    input  wire mfd_pkg::mac_ctl_t                   ctl,
    input  wire logic signed [mfd_pkg::MAC_A_W-1:0] a,
    input  wire logic signed [BW-1:0]                b,
    output logic signed [ACCW-1:0]                   acc
);
    import mfd_pkg::*;

    logic signed [MAC_A_W+BW-1:0] prod;
    logic signed [ACCW-1:0]       prod_ext;
    logic signed [ACCW-1:0]       base;
    logic signed [ACCW-1:0]       acc_reg;

    assign prod     = a * b;
    assign prod_ext = ctl.shift_hi ? (ACCW'(prod) <<< 24) : ACCW'(prod);
    assign base     = ctl.clear ? '0 : acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= base + prod_ext;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/multitap_feedback_delay_unit.sv =====
// ----------------------------------------------------------------------------
// multitap_feedback_delay_unit
// Three-tap interpolated feedback delay: one-pole pre-filter into a ring
// memory, centre/left/right taps with linear interpolation, centre tap fed
// back, left/right/reverb contributions out.
//
//   channel   signals                                     direction
//   -------   -----------------------------------------   ---------
//   in        in_valid, in_ready, sample_in, last_in_block   sink
//   out       out_valid, out_ready, left_add, right_add,     source
//             reverb_add, last_out
//   cfg       cfg_write, cfg_index, cfg_data                 sink
//
// A beat is accepted only from idle, and the next one only once the sequencer is
// back in idle: six tap reads and one write go through the one memory, and
// every product goes through the one shared MAC.
// A result waits in the output register; the next beat is accepted meanwhile
// and stalls only in its last step if the previous result is still held.
// Reset clears the control registers and write pointer and loads the config defaults;
// unwritten memory reads as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multitap_feedback_delay_unit #(
    parameter int DELAY_DEPTH = mfd_pkg::MFD_DELAY_DEPTH,
    parameter int SAMPLE_BITS = mfd_pkg::MFD_SAMPLE_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  wire logic                                last_in_block,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]            left_add,
    output logic signed [SAMPLE_BITS-1:0]            right_add,
    output logic signed [SAMPLE_BITS-1:0]            reverb_add,
    output logic                                     last_out,
    input  wire logic                                cfg_write,
    input  wire logic [mfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [mfd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mfd_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int BW   = (SB + 6 > 25) ? SB + 6 : 25;
    localparam int ACCW = SB + 34;
    localparam int SW   = SB + 17;  // level-weighted tap sum
    localparam int OW   = SB + 5;   // unsaturated channel value

    localparam logic signed [ACCW-1:0] SMAX   = {{(ACCW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [ACCW-1:0] SMIN   = ~SMAX;
    localparam logic signed [ACCW-1:0] HALF8  = {{(ACCW-8){1'b0}}, 8'h80};
    localparam logic signed [ACCW-1:0] HALF14 = {{(ACCW-14){1'b0}}, 14'h2000};
    localparam logic signed [ACCW-1:0] HALF28 = {{(ACCW-28){1'b0}}, 28'h800_0000};

    typedef enum logic [4:0] {
        S_IDLE, S_CN, S_CO, S_LN, S_LO, S_RN, S_RO, S_R1, S_R2, S_FB, S_WR,
        S_LA, S_ML, S_MH, S_RC, S_RA, S_MR, S_MRH, S_RV0, S_RV1, S_FIN
    } state_t;

    function automatic logic signed [SB-1:0] sat_s(input logic signed [ACCW-1:0] v);
        logic signed [ACCW-1:0] c;
        begin
            c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
            sat_s = c[SB-1:0];
        end
    endfunction

    function automatic logic signed [MAC_A_W-1:0] wt_new(input logic on, input logic [7:0] f);
        logic [8:0] w;
        begin
            w = 9'd256 - {1'b0, f};
            wt_new = on ? $signed({8'b0, w}) : '0;
        end
    endfunction

    function automatic logic signed [MAC_A_W-1:0] wt_old(input logic on, input logic [7:0] f);
        wt_old = on ? $signed({9'b0, f}) : '0;
    endfunction

    // Configuration registers.
    logic [DELAY_W-1:0]    centre_delay_reg, left_delay_reg, right_delay_reg;
    logic signed [GAIN_W-1:0] loop_gain_reg, master_level_reg;
    logic [31:0]           prefilter_gains_reg;
    logic [47:0]           tap_levels_reg;
    logic [SEND_W-1:0]     send_level_reg;

    // Control and state.
    state_t                state_reg;
    logic [AW-1:0]         wptr_reg;
    logic signed [SB-1:0]  pre_reg;
    logic                  out_valid_reg;
    logic signed [SB-1:0]  left_reg, right_reg, reverb_reg;
    logic                  last_out_reg;

    // Datapath.
    logic signed [SB-1:0]  x_reg, c_reg, l_reg, r_reg;
    logic                  last_reg;
    logic signed [SW-1:0]  s_reg;
    logic signed [OW-1:0]  wl_reg, wr_reg;

    logic signed [GAIN_W-1:0] gain_in, gain_pole, lvl_c, lvl_l, lvl_r;

    logic          c_on, l_on, r_on;
    logic [7:0]    c_frac, l_frac, r_frac;
    logic [AW-1:0] c_new, c_old, l_new, l_old, r_new, r_old;

    mac_ctl_t                  mac_ctl;
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [BW-1:0]      mac_b;
    logic signed [ACCW-1:0]    acc;
    logic signed [ACCW-1:0]    acc_r8, acc_r14, acc_r28;

    logic                      mem_rd_en, mem_wr_en;
    logic [AW-1:0]             mem_rd_addr;
    logic [SB-1:0]             mem_rd_data;
    logic [SB-1:0]             mem_wr_data;
    logic signed [SB-1:0]      rd_s;
    logic                      out_free;

    assign gain_in   = prefilter_gains_reg[15:0];
    assign gain_pole = prefilter_gains_reg[31:16];
    assign lvl_c     = tap_levels_reg[15:0];
    assign lvl_l     = tap_levels_reg[31:16];
    assign lvl_r     = tap_levels_reg[47:32];

    assign acc_r8  = (acc + HALF8) >>> 8;
    assign acc_r14 = (acc + HALF14) >>> 14;
    assign acc_r28 = (acc + HALF28) >>> 28;
    assign rd_s    = mem_rd_data;
    assign out_free = !out_valid_reg || out_ready;

    mfd_tap_addr #(.DELAY_DEPTH(DELAY_DEPTH), .AW(AW)) u_tap_c (
        .dly(centre_delay_reg), .wptr(wptr_reg), .tap_on(c_on), .frac(c_frac),
        .new_addr(c_new), .old_addr(c_old)
    );

    mfd_tap_addr #(.DELAY_DEPTH(DELAY_DEPTH), .AW(AW)) u_tap_l (
        .dly(left_delay_reg), .wptr(wptr_reg), .tap_on(l_on), .frac(l_frac),
        .new_addr(l_new), .old_addr(l_old)
    );

    mfd_tap_addr #(.DELAY_DEPTH(DELAY_DEPTH), .AW(AW)) u_tap_r (
        .dly(right_delay_reg), .wptr(wptr_reg), .tap_on(r_on), .frac(r_frac),
        .new_addr(r_new), .old_addr(r_old)
    );

    mfd_delay_mem #(.DELAY_DEPTH(DELAY_DEPTH), .SAMPLE_BITS(SB), .AW(AW)) u_mem (
        .clk(clk), .rst_n(rst_n), .rd_en(mem_rd_en), .rd_addr(mem_rd_addr),
        .wr_en(mem_wr_en), .wptr(wptr_reg), .wr_data(mem_wr_data), .rd_data(mem_rd_data)
    );

    mfd_mac #(.BW(BW), .ACCW(ACCW)) u_mac (
        .clk(clk), .ctl(mac_ctl), .a(mac_a), .b(mac_b), .acc(acc)
    );

    assign mem_wr_data = sat_s(acc_r14 + ACCW'(pre_reg));

    // Step schedule: memory read data arrives in the step after its address, and
    // the accumulator result in the step after its operands.
    always_comb
    begin
        mac_ctl     = MAC_HOLD;
        mac_a       = '0;
        mac_b       = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = c_new;
        mem_wr_en   = 1'b0;
        unique case (state_reg)
            S_CN:
            begin
                mac_ctl   = MAC_LOAD;
                mac_a     = MAC_A_W'(gain_in);
                mac_b     = BW'(x_reg);
            end
            S_CO:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = c_new;
                mac_ctl     = MAC_ADD;
                mac_a       = MAC_A_W'(gain_pole);
                mac_b       = BW'(pre_reg);
            end
            S_LN:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = c_old;
                mac_ctl     = MAC_LOAD;
                mac_a       = wt_new(c_on, c_frac);
                mac_b       = BW'(rd_s);
            end
            S_LO:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = l_new;
                mac_ctl     = MAC_ADD;
                mac_a       = wt_old(c_on, c_frac);
                mac_b       = BW'(rd_s);
            end
            S_RN:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = l_old;
                mac_ctl     = MAC_LOAD;
                mac_a       = wt_new(l_on, l_frac);
                mac_b       = BW'(rd_s);
            end
            S_RO:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_new;
                mac_ctl     = MAC_ADD;
                mac_a       = wt_old(l_on, l_frac);
                mac_b       = BW'(rd_s);
            end
            S_R1:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_old;
                mac_ctl     = MAC_LOAD;
                mac_a       = wt_new(r_on, r_frac);
                mac_b       = BW'(rd_s);
            end
            S_R2:
            begin
                mac_ctl = MAC_ADD;
                mac_a   = wt_old(r_on, r_frac);
                mac_b   = BW'(rd_s);
            end
            S_FB:
            begin
                mac_ctl = MAC_LOAD;
                mac_a   = MAC_A_W'(loop_gain_reg);
                mac_b   = BW'(c_reg);
            end
            S_WR, S_RC:
            begin
                mem_wr_en = (state_reg == S_WR);
                mac_ctl   = MAC_LOAD;
                mac_a     = MAC_A_W'(lvl_c);
                mac_b     = BW'(c_reg);
            end
            S_LA:
            begin
                mac_ctl = MAC_ADD;
                mac_a   = MAC_A_W'(lvl_l);
                mac_b   = BW'(l_reg);
            end
            S_RA:
            begin
                mac_ctl = MAC_ADD;
                mac_a   = MAC_A_W'(lvl_r);
                mac_b   = BW'(r_reg);
            end
            S_ML, S_MR:
            begin
                // Master level times the low 24 bits of the tap sum.
                mac_ctl = MAC_LOAD;
                mac_a   = MAC_A_W'(master_level_reg);
                mac_b   = BW'({1'b0, acc[23:0]});
            end
            S_MH, S_MRH:
            begin
                mac_ctl = MAC_ADD_HI;
                mac_a   = MAC_A_W'(master_level_reg);
                mac_b   = BW'(s_reg >>> 24);
            end
            S_RV1:
            begin
                mac_ctl = MAC_LOAD;
                mac_a   = $signed({10'b0, send_level_reg});
                mac_b   = BW'(wl_reg) + BW'(wr_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_delay_reg    <= '0;
            left_delay_reg      <= '0;
            right_delay_reg     <= '0;
            loop_gain_reg       <= '0;
            prefilter_gains_reg <= PREFILTER_RESET;
            tap_levels_reg      <= '0;
            master_level_reg    <= '0;
            send_level_reg      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTRE_DELAY:    centre_delay_reg    <= cfg_data[DELAY_W-1:0];
                REG_LEFT_DELAY:      left_delay_reg      <= cfg_data[DELAY_W-1:0];
                REG_RIGHT_DELAY:     right_delay_reg     <= cfg_data[DELAY_W-1:0];
                REG_LOOP_GAIN:       loop_gain_reg       <= cfg_data[GAIN_W-1:0];
                REG_PREFILTER_GAINS: prefilter_gains_reg <= cfg_data[31:0];
                REG_TAP_LEVELS:      tap_levels_reg      <= cfg_data[47:0];
                REG_MASTER_LEVEL:    master_level_reg    <= cfg_data[GAIN_W-1:0];
                REG_SEND_LEVEL:      send_level_reg      <= cfg_data[SEND_W-1:0];
                default:             ;
            endcase
        end
    end

    // Sequencer, pre-filter state, write pointer and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wptr_reg      <= '0;
            pre_reg       <= '0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
            reverb_reg    <= '0;
            last_out_reg  <= 1'b0;
        end
        else
        begin
            // A new result loaded in the final step keeps the output valid.
            if (out_valid_reg && out_ready && !((state_reg == S_FIN) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_CN;
                    end
                end
                S_CN:  state_reg <= S_CO;
                S_CO:  state_reg <= S_LN;
                S_LN:
                begin
                    pre_reg   <= sat_s(acc_r14);
                    state_reg <= S_LO;
                end
                S_LO:  state_reg <= S_RN;
                S_RN:  state_reg <= S_RO;
                S_RO:  state_reg <= S_R1;
                S_R1:  state_reg <= S_R2;
                S_R2:  state_reg <= S_FB;
                S_FB:  state_reg <= S_WR;
                S_WR:
                begin
                    wptr_reg  <= (wptr_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
                    state_reg <= S_LA;
                end
                S_LA:  state_reg <= S_ML;
                S_ML:  state_reg <= S_MH;
                S_MH:  state_reg <= S_RC;
                S_RC:  state_reg <= S_RA;
                S_RA:  state_reg <= S_MR;
                S_MR:  state_reg <= S_MRH;
                S_MRH: state_reg <= S_RV0;
                S_RV0: state_reg <= S_RV1;
                S_RV1: state_reg <= S_FIN;
                S_FIN:
                begin
                    if (out_free)
                    begin
                        left_reg      <= sat_s(ACCW'(wl_reg));
                        right_reg     <= sat_s(ACCW'(wr_reg));
                        reverb_reg    <= sat_s(acc_r8);
                        last_out_reg  <= last_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Intermediate values of the beat in flight.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg    <= sample_in;
            last_reg <= last_in_block;
        end
        if (state_reg == S_RN)
        begin
            c_reg <= acc_r8[SB-1:0];
        end
        if (state_reg == S_R1)
        begin
            l_reg <= acc_r8[SB-1:0];
        end
        if (state_reg == S_FB)
        begin
            r_reg <= acc_r8[SB-1:0];
        end
        if ((state_reg == S_ML) || (state_reg == S_MR))
        begin
            s_reg <= acc[SW-1:0];
        end
        if (state_reg == S_RC)
        begin
            wl_reg <= acc_r28[OW-1:0];
        end
        if (state_reg == S_RV0)
        begin
            wr_reg <= acc_r28[OW-1:0];
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign left_add   = left_reg;
    assign right_add  = right_reg;
    assign reverb_add = reverb_reg;
    assign last_out   = last_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mfd_checker.sv =====
// ----------------------------------------------------------------------------
// mfd_checker
// Port-level checks for the multitap feedback delay unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_checker #(
    parameter int SAMPLE_BITS = mfd_pkg::MFD_SAMPLE_BITS
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic [SAMPLE_BITS-1:0]             sample_in,
    input wire logic                               last_in_block,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic [SAMPLE_BITS-1:0]             left_add,
    input wire logic [SAMPLE_BITS-1:0]             right_add,
    input wire logic [SAMPLE_BITS-1:0]             reverb_add,
    input wire logic                               last_out,
    input wire logic                               cfg_write,
    input wire logic [mfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input wire logic [mfd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mfd_pkg::*;

    // Only one beat is in work at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a beat is still in work");

    // A result is loaded only from the final step, never from idle.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a beat in work");

    // The memory walk keeps a result from rising right behind an acceptance.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 !$rose(out_valid))
        else $error("result came too early after acceptance");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before the beat was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(left_add) && $stable(right_add)
            && $stable(reverb_add) && $stable(last_out))
        else $error("stalled output beat changed");

endmodule

bind multitap_feedback_delay_unit mfd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mfd_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multitap feedback delay unit. A clocked driver
// feeds send samples from a queue, and a clocked monitor checks every output
// beat against an in-bench model of the pre-filter, the ring memory, the
// interpolated taps and the output mix. Register settings change only while
// the unit is drained, and both channels idle in random bursts.
// ----------------------------------------------------------------------------

module testbench;

    import mfd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam logic [23:0] TAP_MIN = 24'd256;
    localparam logic [23:0] TAP_MAX = 24'((MFD_DELAY_DEPTH - 2) * 256);

    typedef struct {
        logic signed [23:0] sample_val;
        logic               end_flag;
    } frame_in_t;

    typedef struct {
        logic signed [23:0] left_mix;
        logic signed [23:0] right_mix;
        logic signed [23:0] reverb_mix;
        logic               end_flag;
    } mix_out_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [23:0]        sample_in = '0;
    logic                      last_in_block = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [23:0]        left_add;
    logic signed [23:0]        right_add;
    logic signed [23:0]        reverb_add;
    logic                      last_out;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    // Model state and its copy of the registers.
    logic signed [23:0]        delay_mem [0:MFD_DELAY_DEPTH-1];
    logic [15:0]               wr_ptr = '0;
    longint                    pf_state = 0;
    logic [23:0]               centre_dly = '0;
    logic [23:0]               left_dly = '0;
    logic [23:0]               right_dly = '0;
    logic [15:0]               fb_gain = '0;
    logic [31:0]               pf_gains = PREFILTER_RESET;
    logic [47:0]               tap_lvls = '0;
    logic [15:0]               master_lvl = '0;
    logic [6:0]                send_lvl = '0;

    frame_in_t                 send_queue [$];
    mix_out_t                  pending_mix [$];
    frame_in_t                 next_frame;
    mix_out_t                  want;

    int                        idle_pct = 0;
    int                        send_gap = 0;
    int                        gap_age = 0;
    bit                        gap_wait_ready = 1'b0;
    int                        ready_gap = 0;
    int                        mismatch_count = 0;
    int                        quiet_cycles = 0;

    multitap_feedback_delay_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_in     (sample_in),
        .last_in_block (last_in_block),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_add      (left_add),
        .right_add     (right_add),
        .reverb_add    (reverb_add),
        .last_out      (last_out),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Add half an LSB, then floor.
    function automatic longint rnd_shift(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint sat24(longint v);
        longint hi;
        hi = (longint'(1) <<< 23) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint tap_read(logic [23:0] d);
        logic [23:0] dc;
        logic [15:0] i_new;
        logic [15:0] i_old;
        longint      v_new;
        longint      v_old;
        longint      frac;
        if (d == '0)
            return 0;
        dc = d;
        if (dc < TAP_MIN)
            dc = TAP_MIN;
        if (dc > TAP_MAX)
            dc = TAP_MAX;
        i_new = wr_ptr - dc[23:8];
        i_old = i_new - 16'd1;
        v_new = delay_mem[i_new];
        v_old = delay_mem[i_old];
        frac = longint'(dc[7:0]);
        if (frac == 0)
            return v_new;
        return rnd_shift((256 - frac) * v_new + frac * v_old, 8);
    endfunction

    // Advances the model by one frame and returns the mix it produces.
    function automatic mix_out_t delay_step(logic signed [23:0] x_in, logic eob);
        longint   x;
        longint   gin;
        longint   gpole;
        longint   lc;
        longint   ll;
        longint   lr;
        longint   m;
        longint   fb;
        longint   c;
        longint   l;
        longint   r;
        longint   wl;
        longint   wr;
        longint   rv;
        mix_out_t o;
        x = longint'(x_in);
        gin = longint'($signed(pf_gains[15:0]));
        gpole = longint'($signed(pf_gains[31:16]));
        lc = longint'($signed(tap_lvls[15:0]));
        ll = longint'($signed(tap_lvls[31:16]));
        lr = longint'($signed(tap_lvls[47:32]));
        m = longint'($signed(master_lvl));
        fb = longint'($signed(fb_gain));
        pf_state = sat24(rnd_shift(gin * x + gpole * pf_state, 14));
        c = tap_read(centre_dly);
        l = tap_read(left_dly);
        r = tap_read(right_dly);
        delay_mem[wr_ptr] = 24'(sat24(pf_state + rnd_shift(fb * c, 14)));
        wr_ptr = wr_ptr + 16'd1;
        wl = rnd_shift(m * (lc * c + ll * l), 28);
        wr = rnd_shift(m * (lc * c + lr * r), 28);
        rv = rnd_shift(longint'(send_lvl) * (wl + wr), 8);
        o.left_mix = 24'(sat24(wl));
        o.right_mix = 24'(sat24(wr));
        o.reverb_mix = 24'(sat24(rv));
        o.end_flag = eob;
        return o;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_CENTRE_DELAY:    centre_dly = data[23:0];
            REG_LEFT_DELAY:      left_dly = data[23:0];
            REG_RIGHT_DELAY:     right_dly = data[23:0];
            REG_LOOP_GAIN:       fb_gain = data[15:0];
            REG_PREFILTER_GAINS: pf_gains = data[31:0];
            REG_TAP_LEVELS:      tap_lvls = data[47:0];
            REG_MASTER_LEVEL:    master_lvl = data[15:0];
            REG_SEND_LEVEL:      send_lvl = data[6:0];
            default:             ;
        endcase
    endtask

    task automatic program_regs(logic [47:0] c, logic [47:0] l, logic [47:0] r,
                                logic [47:0] fb, logic [47:0] pf, logic [47:0] tl,
                                logic [47:0] ml, logic [47:0] sl);
        write_reg(REG_CENTRE_DELAY, c);
        write_reg(REG_LEFT_DELAY, l);
        write_reg(REG_RIGHT_DELAY, r);
        write_reg(REG_LOOP_GAIN, fb);
        write_reg(REG_PREFILTER_GAINS, pf);
        write_reg(REG_TAP_LEVELS, tl);
        write_reg(REG_MASTER_LEVEL, ml);
        write_reg(REG_SEND_LEVEL, sl);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic push_frame(logic [23:0] s, logic eob);
        frame_in_t f;
        f.sample_val = s;
        f.end_flag = eob;
        send_queue.push_back(f);
    endtask

    // Returns once every queued frame went in and every mix came out.
    task automatic drain();
        do
            @(negedge clk);
        while (send_queue.size() != 0 || in_valid || pending_mix.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [47:0] rand_delay();
        logic [23:0] d;
        case ($urandom_range(0, 5))
            0:       d = '0;
            1:       d = 24'($urandom_range(1, 255));
            2:       d = 24'($urandom_range(256, 12 * 256));
            3:       d = 24'($urandom_range(256, 60 * 256));
            4:       d = 24'($urandom);
            default: d = 24'($urandom_range(int'(TAP_MAX), 24'hFFFFFF));
        endcase
        return {24'($urandom), d};
    endfunction

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 3))
            0:       return 24'($urandom_range(0, 511) - 256);
            1:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    // Input driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample_in <= '0;
            last_in_block <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_mix.push_back(delay_step(sample_in, last_in_block));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    // Some bursts only count while the unit is ready or once they have aged, so that they
                    // fall after its busy stretch rather than inside it.
                    gap_age++;
                    if (!gap_wait_ready || in_ready || gap_age > 30)
                        send_gap--;
                    in_valid <= 1'b0;
                end
                else if (send_queue.size() != 0)
                begin
                    next_frame = send_queue.pop_front();
                    in_valid <= 1'b1;
                    sample_in <= next_frame.sample_val;
                    last_in_block <= next_frame.end_flag;
                    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                    begin
                        send_gap = $urandom_range(1, 10);
                        gap_age = 0;
                        gap_wait_ready = $urandom_range(0, 1);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor and checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_mix.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected output beat: L %0d R %0d rev %0d last %0b",
                                 left_add, right_add, reverb_add, last_out);
                end
                else
                begin
                    want = pending_mix.pop_front();
                    if (left_add !== want.left_mix || right_add !== want.right_mix ||
                        reverb_add !== want.reverb_mix || last_out !== want.end_flag)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected L %0d R %0d rev %0d last %0b, got L %0d R %0d rev %0d last %0b",
                                     want.left_mix, want.right_mix, want.reverb_mix,
                                     want.end_flag, left_add, right_add, reverb_add,
                                     last_out);
                    end
                end
            end
            if (ready_gap > 0)
            begin
                ready_gap--;
                out_ready <= 1'b0;
            end
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                ready_gap = $urandom_range(1, 10) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Ends the run when neither channel nor the register port moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        int ph;
        int n;
        int k;
        int pcts [4];
        pcts = '{0, 20, 50, 80};
        foreach (delay_mem[i])
            delay_mem[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Fractional centre tap with feedback, a left tap below one sample and
        // a right tap beyond the memory, driven with the sample extremes.
        idle_pct = 30;
        program_regs(48'h000180, 48'h000010, 48'hFFFFFF, 48'h4000, 48'h0000_4000,
                     48'h4000_4000_4000, 48'h4000, 48'h7F);
        push_frame(24'h7FFFFF, 1'b0);
        push_frame(24'h800000, 1'b1);
        push_frame(24'h000000, 1'b0);
        push_frame(24'h000001, 1'b0);
        push_frame(24'hFFFFFF, 1'b1);
        push_frame(24'h400000, 1'b0);
        push_frame(24'hC00000, 1'b0);
        push_frame(24'h7FFFFF, 1'b1);
        push_frame(24'h7FFFFF, 1'b0);
        push_frame(24'h000000, 1'b0);
        push_frame(24'h123456, 1'b1);
        push_frame(24'h800000, 1'b0);
        drain();

        // Centre tap off, whole and fractional side taps, gain extremes, and
        // register writes carrying bits above the width of several registers.
        idle_pct = 0;
        program_regs(48'hFFFF_FF00_0000, 48'h000100, 48'hABCD_EF00_0280,
                     48'hFFFF_FFFF_8000, 48'h8000_7FFF, 48'h8000_7FFF_7FFF,
                     48'h1234_5678_8000, 48'hFFFF_FFFF_FF80);
        push_frame(24'h7FFFFF, 1'b1);
        push_frame(24'h7FFFFF, 1'b0);
        push_frame(24'h800000, 1'b0);
        push_frame(24'h800000, 1'b1);
        push_frame(24'h7FFFFF, 1'b0);
        push_frame(24'h000000, 1'b0);
        push_frame(24'h555555, 1'b1);
        push_frame(24'hAAAAAA, 1'b0);
        push_frame(24'h800000, 1'b0);
        push_frame(24'h7FFFFF, 1'b1);
        drain();

        for (ph = 0; ph < 8; ph++)
        begin
            idle_pct = (ph == 7) ? 0 : pcts[$urandom_range(0, 3)];
            if (ph == 0)
                program_regs('1, '1, '1, '1, '1, '1, '1, '1);
            else if (ph == 1)
                program_regs('0, '0, '0, '0, '0, '0, '0, '0);
            else
                program_regs(rand_delay(), rand_delay(), rand_delay(),
                             {$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom});
            n = 120;
            for (k = 0; k < n; k++)
            begin
                push_frame(rand_sample(), 1'($urandom_range(0, 1)));
                // Once in the run the sender holds off until the unit has
                // handed back every pending result.
                if (ph == 3 && k == n / 2)
                    drain();
            end
            drain();
        end

        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && pending_mix.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== multitap_feedback_delay_unit.f =====
rtl/core/mfd_pkg.sv
rtl/core/mfd_tap_addr.sv
rtl/core/mfd_delay_mem.sv
rtl/core/mfd_mac.sv
rtl/core/multitap_feedback_delay_unit.sv
rtl/core/mfd_checker.sv
sim/testbench.sv
